[hdl/int32_to_decimal_ascii_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the integer to decimal text unit
// Shared concurrent assertion forms, all disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef INT32_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define INT32_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// Same-cycle implication.
`define I2DA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2da assertion failed");

// Next-cycle implication.
`define I2DA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2da assertion failed");

`endif

[hdl/i2da_pkg.sv]
// ----------------------------------------------------------------------------
// Integer to decimal text package
// Widths, character codes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package i2da_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 6;
    localparam int LEN_W      = 4;
    localparam int BCD_DIGITS = 10;
    localparam int POS_W      = 4;
    localparam int STEP_W     = 5;

    localparam logic [CHAR_W-1:0] DIGIT_BASE = 6'd48;
    localparam logic [CHAR_W-1:0] MINUS_CODE = 6'd45;

    typedef logic [BCD_DIGITS-1:0][3:0] t_bcd;

    typedef struct packed {
        logic load;
        logic shift;
        logic prep;
        logic advance;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
    } t_dp_sts;

endpackage

[hdl/i2da_channels.sv]
// ----------------------------------------------------------------------------
// Integer to decimal text channels
// Valid/ready interfaces for the input value and the output characters.
// ----------------------------------------------------------------------------
interface i2da_in_if;
    import i2da_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface i2da_out_if;
    import i2da_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic [LEN_W-1:0]  text_length;
    logic              last;

    modport source (output valid, output character, output text_length, output last,
                    input ready);
    modport sink   (input valid, input character, input text_length, input last,
                    output ready);
endinterface

[hdl/i2da_datapath.sv]
// ----------------------------------------------------------------------------
// Integer to decimal text datapath
// Magnitude register, shift-and-add-3 BCD converter and character selection.
// ----------------------------------------------------------------------------
module i2da_datapath (
    input  logic                          i_clk,
    input  logic [i2da_pkg::VALUE_W-1:0]  i_value,
    input  i2da_pkg::t_dp_cmd             i_cmd,
    output i2da_pkg::t_dp_sts             o_sts,
    output logic [i2da_pkg::CHAR_W-1:0]   o_character,
    output logic [i2da_pkg::LEN_W-1:0]    o_text_length,
    output logic                          o_last
);
    import i2da_pkg::*;

    localparam int BCD_W = BCD_DIGITS * 4;

    logic [VALUE_W-1:0] r_bin, n_bin;
    t_bcd               r_bcd, n_bcd;
    logic               r_neg, n_neg;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic               r_sign, n_sign;

    t_bcd               adj;
    logic [BCD_W-1:0]   adj_flat;
    logic [LEN_W-1:0]   ndig;

    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
        adj_flat = adj;
    end

    always_comb begin
        ndig = LEN_W'(1);
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (r_bcd[i] != 4'd0) begin
                ndig = LEN_W'(i + 1);
            end
        end
    end

    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_neg  = r_neg;
        n_len  = r_len;
        n_pos  = r_pos;
        n_sign = r_sign;
        if (i_cmd.load) begin
            n_neg = i_value[VALUE_W-1];
            n_bin = i_value[VALUE_W-1] ? (VALUE_W'(0) - i_value) : i_value;
            n_bcd = '0;
        end else if (i_cmd.shift) begin
            n_bcd = t_bcd'({adj_flat[BCD_W-2:0], r_bin[VALUE_W-1]});
            n_bin = {r_bin[VALUE_W-2:0], 1'b0};
        end else if (i_cmd.prep) begin
            n_pos  = POS_W'(ndig - LEN_W'(1));
            n_len  = ndig + LEN_W'(r_neg);
            n_sign = r_neg;
        end else if (i_cmd.advance) begin
            if (r_sign) begin
                n_sign = 1'b0;
            end else begin
                n_pos = r_pos - POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_neg  <= n_neg;
        r_len  <= n_len;
        r_pos  <= n_pos;
        r_sign <= n_sign;
    end

    assign o_character   = r_sign ? MINUS_CODE : DIGIT_BASE + CHAR_W'(r_bcd[r_pos]);
    assign o_text_length = r_len;
    assign o_last        = !r_sign && (r_pos == POS_W'(0));
    assign o_sts.last    = o_last;

endmodule

[hdl/i2da_controller.sv]
// ----------------------------------------------------------------------------
// Integer to decimal text controller
// Sequences load, 32 conversion steps, digit count and character output.
// ----------------------------------------------------------------------------
module i2da_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  i2da_pkg::t_dp_sts i_sts,
    output i2da_pkg::t_dp_cmd o_cmd,
    output logic              o_in_ready,
    output logic              o_out_valid
);
    import i2da_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_PREP = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_W - 1);

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.shift = 1'b1;
                n_step      = r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    o_cmd.advance = 1'b1;
                    if (i_sts.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);

endmodule

[hdl/int32_to_decimal_ascii_unit.sv]
// Sequence: an accepted word passes through load, the 32-step shift-and-add-3
// converter and a digit-count step before its first character is offered.
// Each character word is then held on the output until it is accepted; a new
// value is accepted only after the last character of the previous one.
// Reset: synchronous active-low reset returns the controller to idle; no
// character is pending after reset.
// ----------------------------------------------------------------------------
// Integer to decimal text unit
// Converts a signed 32-bit word to its decimal ASCII character words.
// ----------------------------------------------------------------------------
module int32_to_decimal_ascii_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    i2da_in_if.sink    i_in,
    i2da_out_if.source o_out
);
    import i2da_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    i2da_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid)
    );

    i2da_datapath u_dp (
        .i_clk         (i_clk),
        .i_value       (i_in.value),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_character   (o_out.character),
        .o_text_length (o_out.text_length),
        .o_last        (o_out.last)
    );

endmodule

[hdl/i2da_checker.sv]
// ----------------------------------------------------------------------------
// Integer to decimal text checker
// Port-level assertions on the character stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "int32_to_decimal_ascii_unit_macros.svh"

module i2da_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [i2da_pkg::CHAR_W-1:0] i_character,
    input logic [i2da_pkg::LEN_W-1:0]  i_text_length,
    input logic                        i_last
);
    import i2da_pkg::*;

    `I2DA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_character) && $stable(i_last))
    `I2DA_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, i_out_valid, !i_in_ready)
    `I2DA_ASSERT_IMP(a_char_code, i_clk, i_rst_n, i_out_valid, (i_character == MINUS_CODE) || ((i_character >= DIGIT_BASE) && (i_character <= DIGIT_BASE + 6'd9)))
    `I2DA_ASSERT_IMP(a_len_range, i_clk, i_rst_n, i_out_valid, (i_text_length >= 4'd1) && (i_text_length <= 4'd11))
    `I2DA_ASSERT_IMP(a_last_digit, i_clk, i_rst_n, i_out_valid && i_last, i_character != MINUS_CODE)

endmodule

bind int32_to_decimal_ascii_unit i2da_checker u_i2da_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_character   (o_out.character),
    .i_text_length (o_out.text_length),
    .i_last        (o_out.last)
);

[tb/i2da_decimal_text_check.sv]
// ----------------------------------------------------------------------------
// Decimal text checker for the integer to decimal text unit
// Watches both channels, predicts the character words of every accepted
// value and compares each delivered character word against the oldest one.
// ----------------------------------------------------------------------------
module i2da_decimal_text_check (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [i2da_pkg::VALUE_W-1:0] i_in_value,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [i2da_pkg::CHAR_W-1:0]  i_out_character,
    input  logic [i2da_pkg::LEN_W-1:0]   i_out_text_length,
    input  logic                         i_out_last,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import i2da_pkg::*;

    localparam int RADIX       = 10;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic [LEN_W-1:0]  text_length;
        logic              last;
    } t_char_word;

    t_char_word expected_chars[$];
    t_char_word want_word;
    t_char_word seen_word;
    int         fail_count = 0;

    function automatic void queue_decimal_text(input logic [VALUE_W-1:0] raw);
        logic               negative;
        logic [VALUE_W-1:0] magnitude;
        logic [3:0]         digits [BCD_DIGITS];
        int                 ndig;
        int                 total;
        int                 pos;
        t_char_word         w;
        negative  = raw[VALUE_W-1];
        magnitude = negative ? (~raw + 1'b1) : raw;
        ndig      = 0;
        do begin
            digits[ndig] = 4'(magnitude % RADIX);
            ndig++;
            magnitude = magnitude / RADIX;
        end while (magnitude != 0);
        total = ndig + (negative ? 1 : 0);
        pos   = 0;
        if (negative) begin
            w.character   = MINUS_CODE;
            w.text_length = LEN_W'(total);
            w.last        = (pos == total - 1);
            expected_chars.push_back(w);
            pos++;
        end
        for (int i = ndig - 1; i >= 0; i--) begin
            w.character   = DIGIT_BASE + CHAR_W'(digits[i]);
            w.text_length = LEN_W'(total);
            w.last        = (pos == total - 1);
            expected_chars.push_back(w);
            pos++;
        end
    endfunction

    task automatic note_failure(input string what, input t_char_word want,
                                input t_char_word got);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%0t: %s: expected char %0d len %0d last %0b, %s %0d len %0d last %0b",
                     $realtime, what, want.character, want.text_length, want.last,
                     "got char", got.character, got.text_length, got.last);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                queue_decimal_text(i_in_value);
            end
            if (i_out_valid && i_out_ready) begin
                seen_word.character   = i_out_character;
                seen_word.text_length = i_out_text_length;
                seen_word.last        = i_out_last;
                if (expected_chars.size() == 0) begin
                    note_failure("character word with nothing expected", '0, seen_word);
                end else begin
                    want_word = expected_chars.pop_front();
                    if (seen_word.character !== want_word.character ||
                        seen_word.text_length !== want_word.text_length ||
                        seen_word.last !== want_word.last) begin
                        note_failure("character word mismatch", want_word, seen_word);
                    end
                end
            end
        end
        o_pending    <= expected_chars.size();
        o_fail_count <= fail_count;
    end

endmodule

[tb/tb_int32_to_decimal_ascii_unit.sv]
// ----------------------------------------------------------------------------
// Testbench for the integer to decimal text unit
// Drives directed and random signed values with random idle gaps on both
// channels, including a long receiver hold-off and a full drain, and takes
// the verdict from the decimal text checker.
// ----------------------------------------------------------------------------
module tb_int32_to_decimal_ascii_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import i2da_pkg::*;

    localparam int  CLK_PERIOD   = 20;
    localparam int  RESET_CYCLES = 8;
    localparam int  RANDOM_ITEMS = 250;
    localparam int  HOLD_CYCLES  = 400;
    localparam int  DRAIN_CYCLES = 60;
    localparam int  TIMEOUT_NS   = 15_000_000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_chars;
    bit   hold_request = 0;
    bit   sender_gaps_on = 1;

    logic [VALUE_W-1:0] directed_values [] = '{
        32'd0, 32'd1, -32'd1, 32'd7, 32'd9, 32'd10, -32'd10, 32'd99, 32'd100,
        -32'd100, 32'd12345, -32'd67890, 32'd999999999, 32'd1000000000,
        -32'd999999999, -32'd1000000000, 32'd1234567890, -32'd1234567890,
        32'd2147483647, -32'd2147483647, 32'h8000_0000, 32'h5555_5555,
        32'hAAAA_AAAA
    };

    i2da_in_if  in_ch ();
    i2da_out_if out_ch ();

    int32_to_decimal_ascii_unit uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    i2da_decimal_text_check u_decimal_text_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_ch.valid),
        .i_in_ready        (in_ch.ready),
        .i_in_value        (in_ch.value),
        .i_out_valid       (out_ch.valid),
        .i_out_ready       (out_ch.ready),
        .i_out_character   (out_ch.character),
        .i_out_text_length (out_ch.text_length),
        .i_out_last        (out_ch.last),
        .o_fail_count      (fail_count),
        .o_pending         (pending_chars)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_int32_to_decimal_ascii_unit failed");
        $finish;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        int     kind;
        int     ndig;
        bit     neg;
        longint pow;
        longint lo;
        longint hi;
        longint mag;
        kind = $urandom_range(0, 99);
        neg  = $urandom_range(0, 1);
        pow  = 1;
        if (kind < 30) begin
            return $urandom;
        end else if (kind < 70) begin
            ndig = $urandom_range(1, 10);
            repeat (ndig - 1) pow *= 10;
            lo = (ndig == 1) ? 0 : pow;
            hi = pow * 10 - 1;
            if (!neg && hi > 64'd2147483647) hi = 64'd2147483647;
            if (neg && hi > 64'd2147483648) hi = 64'd2147483648;
            mag = lo + longint'({32'd0, $urandom}) % (hi - lo + 1);
        end else if (kind < 85) begin
            ndig = $urandom_range(0, 9);
            repeat (ndig) pow *= 10;
            mag = pow + $urandom_range(0, 2) - 1;
        end else begin
            mag = $urandom_range(0, 20);
        end
        return neg ? VALUE_W'(-mag) : VALUE_W'(mag);
    endfunction

    task automatic send_value(input logic [VALUE_W-1:0] v);
        int gap;
        gap = sender_gaps_on ? idle_gap() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_chars != 0);
    endtask

    initial begin
        int run;
        int gap;
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (hold_request) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 0;
            end else begin
                run = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
                out_ch.ready <= 1'b1;
                repeat (run) @(posedge clk);
                gap = idle_gap();
                if (gap > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    initial begin
        rst_n       <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_values[i]) send_value(directed_values[i]);
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 60) hold_request = 1;
            if (n == 150) wait_drained();
            sender_gaps_on = !(n >= 180 && n < 230);
            send_value(random_value());
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("tb_int32_to_decimal_ascii_unit passed");
        end else begin
            $display("tb_int32_to_decimal_ascii_unit failed");
        end
        $finish;
    end

endmodule
